[src/ima_dec_pkg.sv]
// ----------------------------------------------------------------------------
// ima_dec_pkg
// Shared types, constants and tables of the IMA-style ADPCM nibble decoder.
// ----------------------------------------------------------------------------
package ima_dec_pkg;

	localparam int unsigned CODE_W   = 4;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned STEP_W   = 15;
	localparam int unsigned SAMPLE_W = 16;

	localparam logic [POS_W-1:0] POS_MAX = 7'd88;

	localparam logic signed [SAMPLE_W+1:0] SAMPLE_MIN = -18'sd32768;
	localparam logic signed [SAMPLE_W+1:0] SAMPLE_MAX = 18'sd32767;

	// index adjustment per code; the sign bit of the code does not matter
	localparam logic signed [4:0] POS_DELTA [0:15] = '{
		-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8,
		-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
	};

	// step size per index
	localparam logic [STEP_W-1:0] STEP_ROM [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
		15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
		15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
		15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
		15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
		15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282,
		15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499,
		15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871,
		15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845, 15'd8630, 15'd9493,
		15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818,
		15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
		15'd32767
	};

	// decoder state carried from one code to the next
	typedef struct packed {
		logic [POS_W-1:0]           pos;
		logic signed [SAMPLE_W-1:0] pred;
		logic [STEP_W-1:0]          step;
	} dec_state_t;

endpackage

[src/ima_dec_nibble.sv]
// ----------------------------------------------------------------------------
// ima_dec_nibble
// Decodes one 4-bit ADPCM code: index update, difference, saturating
// predictor update and step lookup, all combinational.
// ----------------------------------------------------------------------------
module ima_dec_nibble (
	input  ima_dec_pkg::dec_state_t           st_in,
	input  logic [ima_dec_pkg::CODE_W-1:0]    code,
	output ima_dec_pkg::dec_state_t           st_out
);
	import ima_dec_pkg::*;

	logic signed [POS_W:0]      pos_sum;
	logic [POS_W-1:0]           pos_new;
	logic [SAMPLE_W-1:0]        diff;
	logic signed [SAMPLE_W+1:0] diff_s;
	logic signed [SAMPLE_W+1:0] acc;
	logic signed [SAMPLE_W-1:0] pred_new;

	// move the index and clamp it to 0..88
	always_comb begin
		pos_sum = $signed({1'b0, st_in.pos}) + (POS_W+1)'(POS_DELTA[code]);
		if (pos_sum < 0) begin
			pos_new = '0;
		end else if (pos_sum > $signed({1'b0, POS_MAX})) begin
			pos_new = POS_MAX;
		end else begin
			pos_new = pos_sum[POS_W-1:0];
		end
	end

	// build the difference from the previous step size
	always_comb begin
		diff = SAMPLE_W'(st_in.step >> 3);
		if (code[0]) diff = diff + SAMPLE_W'(st_in.step >> 2);
		if (code[1]) diff = diff + SAMPLE_W'(st_in.step >> 1);
		if (code[2]) diff = diff + SAMPLE_W'(st_in.step);
		diff_s = $signed({2'b00, diff});
		if (code[3]) diff_s = -diff_s;
	end

	// add to the predictor and saturate to 16 bits
	always_comb begin
		acc = (SAMPLE_W+2)'(st_in.pred) + diff_s;
		if (acc < SAMPLE_MIN) begin
			pred_new = SAMPLE_MIN[SAMPLE_W-1:0];
		end else if (acc > SAMPLE_MAX) begin
			pred_new = SAMPLE_MAX[SAMPLE_W-1:0];
		end else begin
			pred_new = acc[SAMPLE_W-1:0];
		end
	end

	assign st_out.pos  = pos_new;
	assign st_out.pred = pred_new;
	assign st_out.step = STEP_ROM[pos_new];

endmodule

[src/ima_adpcm_nibble_decoder.sv]
// ----------------------------------------------------------------------------
// ima_adpcm_nibble_decoder
// Decodes one packed byte of two IMA-style ADPCM codes, low nibble first,
// into two signed 16-bit samples.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------
//   input   | in_valid / in_ready  | code_byte[7:0], first
//   output  | out_valid / out_ready| sample_a[15:0], sample_b[15:0]
//
// One byte per cycle sustained while out_ready stays high; a request passes
// through the input register and then the result register.
// Both nibbles are decoded in the cycle the input register advances, which
// is also when the decoder state is updated.
// Reset empties both registers and clears index, predictor and step size.
// A stalled result holds the input register; a new byte is still taken
// while the result register drains in the same cycle.
// ----------------------------------------------------------------------------
module ima_adpcm_nibble_decoder (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [7:0]                               code_byte,
	input  logic                                     first,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [ima_dec_pkg::SAMPLE_W-1:0]  sample_a,
	output logic signed [ima_dec_pkg::SAMPLE_W-1:0]  sample_b
);
	import ima_dec_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        adv;

	dec_state_t  state_q;
	dec_state_t  st_base;
	dec_state_t  st_mid;
	dec_state_t  st_end;

	logic                        out_valid_q;
	logic signed [SAMPLE_W-1:0]  sample_a_q;
	logic signed [SAMPLE_W-1:0]  sample_b_q;

	// advance the input register when the result register is free
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// hold the request in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= code_byte;
			first_s1 <= first;
		end
	end

	// clear the state ahead of a first byte
	assign st_base = first_s1 ? '0 : state_q;

	ima_dec_nibble u_nib_lo (
		.st_in  (st_base),
		.code   (byte_s1[3:0]),
		.st_out (st_mid)
	);

	ima_dec_nibble u_nib_hi (
		.st_in  (st_mid),
		.code   (byte_s1[7:4]),
		.st_out (st_end)
	);

	// update the decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= st_end;
		end
	end

	// load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_a_q <= st_mid.pred;
			sample_b_q <= st_end.pred;
		end
	end

	assign out_valid = out_valid_q;
	assign sample_a  = sample_a_q;
	assign sample_b  = sample_b_q;

	// index stays within the step table
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pos <= POS_MAX)
		else $error("step index beyond table");

	// an advancing request always lands in the result register
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced request lost");

	// a held result blocks the input register from advancing
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !adv)
		else $error("result overwritten while stalled");

	// state changes only when a request is decoded
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("state changed without a request");

endmodule
